@@ sv/sdf_blend_unit_assert.svh @@
// Assertion macros for the distance blend unit checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef SDF_BLEND_UNIT_ASSERT_SVH
`define SDF_BLEND_UNIT_ASSERT_SVH

// Check cons in the same cycle whenever ante holds.
`define SDFB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons at the delay dly after ante.
`define SDFB_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

@@ sv/sdfb_pkg.sv @@
// Shared constants, codes and pipeline types of the distance blend unit.
// No dependencies.
`timescale 1ns / 1ps

package sdfb_pkg;

  localparam int DIST_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 31;
  localparam int MODE_W  = 3;
  localparam int ADDR_W  = 2;
  localparam int XW      = DIST_W + 2;
  localparam int MAG_W   = DIST_W + 1;
  localparam int HARD_W  = DIST_W + 1;
  localparam int H_W     = FRAC_W + 1;
  localparam int Q_W     = DIST_W + CFG_W;
  localparam int HH_W    = 2 * H_W;
  localparam int G_W     = FRAC_W - 1;
  localparam int KG_W    = CFG_W + G_W;
  localparam int CORR_W  = KG_W - FRAC_W;
  localparam int PM_W    = MAG_W + H_W;
  localparam int P_W     = PM_W - FRAC_W;
  localparam int R_W     = DIST_W + 4;
  localparam int LATENCY = 5;

  localparam logic [H_W-1:0]   ONE_Q  = H_W'(1) << FRAC_W;
  localparam logic [H_W-1:0]   HALF_Q = H_W'(1) << (FRAC_W - 1);
  localparam logic [CFG_W-1:0] K_RST  = CFG_W'(1) << FRAC_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_UNION  = 3'd0,
    MODE_INTER  = 3'd1,
    MODE_SUB    = 3'd2,
    MODE_SUNION = 3'd3,
    MODE_SINT   = 3'd4,
    MODE_SSUB   = 3'd5
  } mode_t;

  typedef enum logic [ADDR_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_K    = 2'd1,
    CFG_INV  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                     smooth;
    logic                     is_min;
    logic                     e_pos;
    logic                     d_neg;
    logic [MAG_W-1:0]         mag;
    logic signed [XW-1:0]     x;
    logic signed [HARD_W-1:0] hard;
  } blend_ctl_t;

  typedef struct packed {
    logic [CFG_W-1:0] k;
    logic [CFG_W-1:0] inv;
  } coef_t;

endpackage

@@ sv/sdfb_front.sv @@
// Stage 1 of the blend pipeline: operand selection, difference and hard blends.
// Depends on sdfb_pkg.
`timescale 1ns / 1ps

module sdfb_front import sdfb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_i,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic signed [DIST_W-1:0] dist_a_i,
  input  logic signed [DIST_W-1:0] dist_b_i,
  output logic                     vld_o,
  output blend_ctl_t               ctl_o
);

  logic signed [XW-1:0] a_x;
  logic signed [XW-1:0] b_x;
  logic signed [XW-1:0] nb_x;
  logic signed [XW-1:0] d;
  logic signed [XW-1:0] d_abs;
  logic                 vld_r, vld_nxt;
  blend_ctl_t           ctl_r, ctl_nxt;

  always_comb begin
    a_x  = XW'(dist_a_i);
    b_x  = XW'(dist_b_i);
    nb_x = -b_x;
    vld_nxt = vld_i;
    ctl_nxt = '0;
    ctl_nxt.x = b_x;
    d = a_x - b_x;
    ctl_nxt.hard = (a_x < b_x) ? HARD_W'(a_x) : HARD_W'(b_x);
    case (mode_i)
      MODE_INTER: begin
        ctl_nxt.hard = (a_x > b_x) ? HARD_W'(a_x) : HARD_W'(b_x);
      end
      MODE_SUB: begin
        ctl_nxt.hard = (a_x > nb_x) ? HARD_W'(a_x) : HARD_W'(nb_x);
      end
      MODE_SUNION: begin
        ctl_nxt.smooth = 1'b1;
        ctl_nxt.is_min = 1'b1;
      end
      MODE_SINT: begin
        ctl_nxt.smooth = 1'b1;
      end
      MODE_SSUB: begin
        ctl_nxt.smooth = 1'b1;
        ctl_nxt.x = a_x;
        d = nb_x - a_x;
      end
      default: begin
      end
    endcase
    d_abs = (d < 0) ? -d : d;
    ctl_nxt.d_neg = (d < 0);
    ctl_nxt.e_pos = ctl_nxt.is_min ? (d <= 0) : (d >= 0);
    ctl_nxt.mag = MAG_W'(d_abs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r <= ctl_nxt;
  end

  assign vld_o = vld_r;
  assign ctl_o = ctl_r;

endmodule

@@ sv/sdfb_smooth.sv @@
// Stages 2 to 4 of the blend pipeline: blend weight, weighted difference and
// smoothing correction. Depends on sdfb_pkg.
`timescale 1ns / 1ps

module sdfb_smooth import sdfb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  vld_i,
  input  blend_ctl_t            ctl_i,
  input  coef_t                 coef_i,
  output logic                  vld_o,
  output blend_ctl_t            ctl_o,
  output logic signed [P_W-1:0] p_o,
  output logic [CORR_W-1:0]     corr_o
);

  // stage 2: scaled distance
  logic             v2_r;
  blend_ctl_t       ctl2_r;
  logic [Q_W-1:0]   q2_r, q2_nxt;
  logic             big2_r, big2_nxt;

  // stage 3: weight products
  logic             v3_r;
  blend_ctl_t       ctl3_r;
  logic [HH_W-1:0]  hh3_r, hh3_nxt;
  logic [PM_W-1:0]  pm3_r, pm3_nxt;
  logic             sat3;
  logic [H_W-1:0]   off3;
  logic [H_W-1:0]   h3;
  logic [H_W-1:0]   hc3;

  // stage 4: correction and signed product
  logic                  v4_r;
  blend_ctl_t            ctl4_r;
  logic [G_W-1:0]        g4;
  logic [KG_W-1:0]       kg4;
  logic [P_W-1:0]        pmag4;
  logic [CORR_W-1:0]     corr4_r, corr4_nxt;
  logic signed [P_W-1:0] p4_r, p4_nxt;

  always_comb begin
    q2_nxt   = Q_W'(ctl_i.mag[DIST_W-1:0]) * Q_W'(coef_i.inv);
    big2_nxt = ctl_i.mag[MAG_W-1] && (coef_i.inv != '0);
  end

  always_comb begin
    sat3 = big2_r || (q2_r[Q_W-1:2*FRAC_W] != '0);
    off3 = sat3 ? HALF_Q : H_W'(q2_r[2*FRAC_W-1:FRAC_W+1]);
    h3   = ctl2_r.e_pos ? (HALF_Q + off3) : (HALF_Q - off3);
    hc3  = ONE_Q - h3;
    hh3_nxt = HH_W'(h3) * HH_W'(hc3);
    pm3_nxt = PM_W'(ctl2_r.mag) * PM_W'(h3);
  end

  always_comb begin
    g4        = hh3_r[FRAC_W +: G_W];
    kg4       = KG_W'(coef_i.k) * KG_W'(g4);
    corr4_nxt = kg4[FRAC_W +: CORR_W];
    pmag4     = pm3_r[PM_W-1:FRAC_W];
    p4_nxt    = ctl3_r.d_neg ? -$signed(pmag4) : $signed(pmag4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= vld_i;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ctl2_r  <= ctl_i;
    q2_r    <= q2_nxt;
    big2_r  <= big2_nxt;
    ctl3_r  <= ctl2_r;
    hh3_r   <= hh3_nxt;
    pm3_r   <= pm3_nxt;
    ctl4_r  <= ctl3_r;
    corr4_r <= corr4_nxt;
    p4_r    <= p4_nxt;
  end

  assign vld_o  = v4_r;
  assign ctl_o  = ctl4_r;
  assign p_o    = p4_r;
  assign corr_o = corr4_r;

endmodule

@@ sv/sdfb_sat.sv @@
// Stage 5 of the blend pipeline: final sum, mode select and saturation.
// Depends on sdfb_pkg.
`timescale 1ns / 1ps

module sdfb_sat import sdfb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_i,
  input  blend_ctl_t               ctl_i,
  input  logic signed [P_W-1:0]    p_i,
  input  logic [CORR_W-1:0]        corr_i,
  output logic                     vld_o,
  output logic signed [DIST_W-1:0] dist_o
);

  localparam logic signed [R_W-1:0] R_MAX =
    {{(R_W-DIST_W+1){1'b0}}, {(DIST_W-1){1'b1}}};
  localparam logic signed [R_W-1:0] R_MIN = ~R_MAX;

  logic signed [R_W-1:0]    corr_s;
  logic signed [R_W-1:0]    sum;
  logic signed [R_W-1:0]    sel;
  logic                     vld_r, vld_nxt;
  logic signed [DIST_W-1:0] dist_r, dist_nxt;

  always_comb begin
    corr_s = $signed(R_W'(corr_i));
    sum = R_W'(ctl_i.x) + R_W'(p_i) + (ctl_i.is_min ? -corr_s : corr_s);
    sel = ctl_i.smooth ? sum : R_W'(ctl_i.hard);
    if (sel > R_MAX) begin
      dist_nxt = DIST_W'(R_MAX);
    end else if (sel < R_MIN) begin
      dist_nxt = DIST_W'(R_MIN);
    end else begin
      dist_nxt = DIST_W'(sel);
    end
    vld_nxt = vld_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  assign vld_o  = vld_r;
  assign dist_o = dist_r;

endmodule

@@ sv/sdf_blend_unit.sv @@
// Top level of the signed-distance blend unit: configuration registers and
// the five-stage blend pipeline. Depends on sdfb_pkg, sdfb_front, sdfb_smooth, sdfb_sat.
`timescale 1ns / 1ps

// Usage:
//   A request enters when start is high and busy is low; busy is high only
//   while rst_n is asserted. One request per cycle is taken, back to back.
//   in_dist_a / in_dist_b are signed Q16.16 distances.
//   Each request yields one result: out_valid is high for one cycle with
//   out_blended_distance; the request passes the operand stage, the weight
//   scale, weight product and correction stages and the output stage in turn.
//   Results come out in request order; throughput is one result per cycle.
//   The pipeline is built from the chain of three multiplies (weight scale,
//   weight products, correction scale), each followed by a register, plus
//   the operand stage and the output saturation stage.
//   The receiver cannot stall; results are never held.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 blend
//   mode, 1 smoothness k, 2 reciprocal of k; index 3 is ignored). Write only
//   while no request is in flight.
//   Synchronous reset clears the pipeline valid bits and loads mode union,
//   k = 1.0 and 1/k = 1.0.

module sdf_blend_unit import sdfb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DIST_W-1:0] in_dist_a,
  input  logic signed [DIST_W-1:0] in_dist_b,
  output logic                     out_valid,
  output logic signed [DIST_W-1:0] out_blended_distance,
  input  logic                     cfg_we,
  input  logic [ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  logic [MODE_W-1:0]     mode_r, mode_nxt;
  coef_t                 coef_r, coef_nxt;
  logic                  in_vld;
  logic                  v1;
  blend_ctl_t            ctl1;
  logic                  v4;
  blend_ctl_t            ctl4;
  logic signed [P_W-1:0] p4;
  logic [CORR_W-1:0]     corr4;

  always_comb begin
    mode_nxt = mode_r;
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_MODE: mode_nxt     = cfg_wdata[MODE_W-1:0];
        CFG_K:    coef_nxt.k   = cfg_wdata;
        CFG_INV:  coef_nxt.inv = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_UNION;
      coef_r.k   <= K_RST;
      coef_r.inv <= K_RST;
    end else begin
      mode_r <= mode_nxt;
      coef_r <= coef_nxt;
    end
  end

  assign busy   = ~rst_n;
  assign in_vld = start & ~busy;

  sdfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (in_vld),
    .mode_i   (mode_r),
    .dist_a_i (in_dist_a),
    .dist_b_i (in_dist_b),
    .vld_o    (v1),
    .ctl_o    (ctl1)
  );

  sdfb_smooth u_smooth (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v1),
    .ctl_i  (ctl1),
    .coef_i (coef_r),
    .vld_o  (v4),
    .ctl_o  (ctl4),
    .p_o    (p4),
    .corr_o (corr4)
  );

  sdfb_sat u_sat (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v4),
    .ctl_i  (ctl4),
    .p_i    (p4),
    .corr_i (corr4),
    .vld_o  (out_valid),
    .dist_o (out_blended_distance)
  );

endmodule

@@ sv/sdfb_checker.sv @@
// Port-level checker for the distance blend unit, bound to the top level.
// Depends on sdfb_pkg and sdf_blend_unit_assert.svh.
`timescale 1ns / 1ps
`include "sdf_blend_unit_assert.svh"

module sdfb_checker import sdfb_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `SDFB_ASSERT_DLY(a_req_to_result, start && !busy, LATENCY, out_valid, "request produced no result")
  `SDFB_ASSERT_IMPL(a_result_has_req, out_valid, $past(start && !busy, LATENCY), "result without request")
  `SDFB_ASSERT_IMPL(a_quiet_after_reset, $rose(rst_n), !out_valid, "result right after reset")

endmodule

bind sdf_blend_unit sdfb_checker u_sdfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
